[design/ims_pkg.sv]
// ----------------------------------------------------------------------------
// ims_pkg: shared types and constants of the bilinear image sampler
// Widths of the stream fields, the store geometry and the control structs
// passed between the address front end and the blend back end.
// ----------------------------------------------------------------------------
`default_nettype none

package ims_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int PIXEL_BITS = 16;
    localparam int FRAC_BITS  = 8;

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int IDX_X_BITS  = $clog2(MAX_WIDTH);
    localparam int IDX_Y_BITS  = $clog2(MAX_HEIGHT);

    // fixed field widths of the stream and register map
    localparam int MODE_BITS   = 1;
    localparam int LOAD_BITS   = 16;
    localparam int VALUE_BITS  = 16;
    localparam int COORD_BITS  = 20;
    localparam int RESULT_BITS = 16;
    localparam int WIN_BITS    = 12;
    localparam int DIM_BITS    = 9;
    localparam int CFG_BITS    = 12;
    localparam int CFG_IDX_BITS = 3;

    localparam int INT_BITS  = COORD_BITS - FRAC_BITS;
    // room for the window offset and the +1 neighbour
    localparam int OFS_BITS  = ((INT_BITS > WIN_BITS) ? INT_BITS : WIN_BITS) + 2;
    localparam int WEFF_X_BITS = $clog2(MAX_WIDTH + 1);
    localparam int WEFF_Y_BITS = $clog2(MAX_HEIGHT + 1);
    localparam int LERP_BITS = PIXEL_BITS + FRAC_BITS;

    localparam int S_FIELD_BITS = LOAD_BITS + VALUE_BITS + 2 * COORD_BITS;
    localparam int S_DATA_BITS  = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS  = ((RESULT_BITS + 7) / 8) * 8;

    // four neighbour taps, one store copy each
    localparam int TAP_COUNT = 4;
    localparam int TAP_00 = 0;
    localparam int TAP_10 = 1;
    localparam int TAP_01 = 2;
    localparam int TAP_11 = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_FILTER_MODE  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_MIN_X = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_MIN_Y = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd4;

    localparam logic FILTER_NEAREST  = 1'b0;
    localparam logic FILTER_BILINEAR = 1'b1;
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef struct packed {
        logic                       filter_mode;
        logic signed [WIN_BITS-1:0] window_min_x;
        logic signed [WIN_BITS-1:0] window_min_y;
        logic [DIM_BITS-1:0]        image_width;
        logic [DIM_BITS-1:0]        image_height;
    } cfg_t;

    typedef struct packed {
        logic                 valid;
        logic                 sample;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
    } ctl_t;

endpackage

`default_nettype wire

[design/ims_ram.sv]
// ----------------------------------------------------------------------------
// ims_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ims_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[design/ims_addr.sv]
// ----------------------------------------------------------------------------
// ims_addr: coordinate front end of the sampler
// Three stages: integer coordinate and fraction, edge clamp of both
// neighbours, row-major addresses of the four taps.
// ----------------------------------------------------------------------------
`default_nettype none

module ims_addr (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 advance,
    input  wire logic                                 in_valid,
    input  wire logic                                 in_sample,
    input  wire logic [ims_pkg::LOAD_BITS-1:0]        load_address,
    input  wire logic [ims_pkg::VALUE_BITS-1:0]       pixel_value,
    input  wire logic [ims_pkg::COORD_BITS-1:0]       coord_x,
    input  wire logic [ims_pkg::COORD_BITS-1:0]       coord_y,
    input  wire ims_pkg::cfg_t                        cfg,
    output ims_pkg::ctl_t                             ctl,
    output logic [ims_pkg::TAP_COUNT-1:0][ims_pkg::ADDR_BITS-1:0] rd_addr,
    output logic [ims_pkg::LOAD_BITS-1:0]             wr_addr,
    output logic [ims_pkg::VALUE_BITS-1:0]            wr_data
);

    localparam int OW = ims_pkg::OFS_BITS;
    localparam int XB = ims_pkg::IDX_X_BITS;
    localparam int YB = ims_pkg::IDX_Y_BITS;
    localparam int AB = ims_pkg::ADDR_BITS;

    // stage 1
    ims_pkg::ctl_t                        st1_ctl_reg;
    logic signed [OW-1:0]                 st1_x_reg;
    logic signed [OW-1:0]                 st1_y_reg;
    logic [ims_pkg::LOAD_BITS-1:0]        st1_load_reg;
    logic [ims_pkg::VALUE_BITS-1:0]       st1_pixel_reg;
    // stage 2
    ims_pkg::ctl_t                        st2_ctl_reg;
    logic [XB-1:0]                        st2_cx0_reg;
    logic [XB-1:0]                        st2_cx1_reg;
    logic [YB-1:0]                        st2_cy0_reg;
    logic [YB-1:0]                        st2_cy1_reg;
    logic [ims_pkg::LOAD_BITS-1:0]        st2_load_reg;
    logic [ims_pkg::VALUE_BITS-1:0]       st2_pixel_reg;
    // stage 3
    ims_pkg::ctl_t                                 st3_ctl_reg;
    logic [ims_pkg::TAP_COUNT-1:0][AB-1:0]         st3_addr_reg;
    logic [ims_pkg::LOAD_BITS-1:0]                 st3_load_reg;
    logic [ims_pkg::VALUE_BITS-1:0]                st3_pixel_reg;

    logic signed [ims_pkg::INT_BITS-1:0]  floor_x;
    logic signed [ims_pkg::INT_BITS-1:0]  floor_y;
    logic                                 up_x;
    logic                                 up_y;
    logic                                 bilinear;
    ims_pkg::ctl_t                        st1_ctl_next;
    logic signed [OW-1:0]                 st1_x_next;
    logic signed [OW-1:0]                 st1_y_next;
    logic [ims_pkg::WEFF_X_BITS-1:0]      w_eff;
    logic [ims_pkg::WEFF_Y_BITS-1:0]      h_eff;
    logic signed [OW-1:0]                 x1;
    logic signed [OW-1:0]                 y1;
    logic [XB-1:0]                        st2_cx0_next;
    logic [XB-1:0]                        st2_cx1_next;
    logic [YB-1:0]                        st2_cy0_next;
    logic [YB-1:0]                        st2_cy1_next;
    logic [AB:0]                          row0;
    logic [AB:0]                          row1;
    logic [ims_pkg::TAP_COUNT-1:0][AB-1:0] st3_addr_next;

    function automatic logic [XB-1:0] clamp_x(input logic signed [OW-1:0] v,
                                              input logic [ims_pkg::WEFF_X_BITS-1:0] n);
        logic signed [OW-1:0] ns;
        logic [ims_pkg::WEFF_X_BITS-1:0] last;
        ns   = $signed(OW'(n));
        last = n - 1'b1;
        if (v < 0)
            return '0;
        else if (v >= ns)
            return last[XB-1:0];
        else
            return v[XB-1:0];
    endfunction

    function automatic logic [YB-1:0] clamp_y(input logic signed [OW-1:0] v,
                                              input logic [ims_pkg::WEFF_Y_BITS-1:0] n);
        logic signed [OW-1:0] ns;
        logic [ims_pkg::WEFF_Y_BITS-1:0] last;
        ns   = $signed(OW'(n));
        last = n - 1'b1;
        if (v < 0)
            return '0;
        else if (v >= ns)
            return last[YB-1:0];
        else
            return v[YB-1:0];
    endfunction

    // stage 1: floor for bilinear, truncation toward zero for nearest
    always_comb
    begin
        bilinear = (cfg.filter_mode == ims_pkg::FILTER_BILINEAR);
        floor_x  = $signed(coord_x[ims_pkg::COORD_BITS-1:ims_pkg::FRAC_BITS]);
        floor_y  = $signed(coord_y[ims_pkg::COORD_BITS-1:ims_pkg::FRAC_BITS]);
        up_x     = !bilinear && coord_x[ims_pkg::COORD_BITS-1]
                   && (|coord_x[ims_pkg::FRAC_BITS-1:0]);
        up_y     = !bilinear && coord_y[ims_pkg::COORD_BITS-1]
                   && (|coord_y[ims_pkg::FRAC_BITS-1:0]);
        st1_x_next = OW'(floor_x) + $signed(OW'(up_x)) - OW'(cfg.window_min_x);
        st1_y_next = OW'(floor_y) + $signed(OW'(up_y)) - OW'(cfg.window_min_y);
        st1_ctl_next.valid  = in_valid;
        st1_ctl_next.sample = in_sample;
        // nearest blends with zero weights and so returns the top-left tap
        st1_ctl_next.fx = bilinear ? coord_x[ims_pkg::FRAC_BITS-1:0] : '0;
        st1_ctl_next.fy = bilinear ? coord_y[ims_pkg::FRAC_BITS-1:0] : '0;
    end

    // stage 2: clamp both neighbours to the stored image
    always_comb
    begin
        if (cfg.image_width == '0)
            w_eff = ims_pkg::WEFF_X_BITS'(1);
        else if (int'(cfg.image_width) > ims_pkg::MAX_WIDTH)
            w_eff = ims_pkg::WEFF_X_BITS'(ims_pkg::MAX_WIDTH);
        else
            w_eff = ims_pkg::WEFF_X_BITS'(cfg.image_width);

        if (cfg.image_height == '0)
            h_eff = ims_pkg::WEFF_Y_BITS'(1);
        else if (int'(cfg.image_height) > ims_pkg::MAX_HEIGHT)
            h_eff = ims_pkg::WEFF_Y_BITS'(ims_pkg::MAX_HEIGHT);
        else
            h_eff = ims_pkg::WEFF_Y_BITS'(cfg.image_height);

        x1 = st1_x_reg + $signed(OW'(1));
        y1 = st1_y_reg + $signed(OW'(1));
        st2_cx0_next = clamp_x(st1_x_reg, w_eff);
        st2_cx1_next = clamp_x(x1, w_eff);
        st2_cy0_next = clamp_y(st1_y_reg, h_eff);
        st2_cy1_next = clamp_y(y1, h_eff);
    end

    // stage 3: row-major addresses
    always_comb
    begin
        row0 = (AB + 1)'(st2_cy0_reg) * (AB + 1)'(w_eff);
        row1 = (AB + 1)'(st2_cy1_reg) * (AB + 1)'(w_eff);
        st3_addr_next[ims_pkg::TAP_00] = AB'(row0 + (AB + 1)'(st2_cx0_reg));
        st3_addr_next[ims_pkg::TAP_10] = AB'(row0 + (AB + 1)'(st2_cx1_reg));
        st3_addr_next[ims_pkg::TAP_01] = AB'(row1 + (AB + 1)'(st2_cx0_reg));
        st3_addr_next[ims_pkg::TAP_11] = AB'(row1 + (AB + 1)'(st2_cx1_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_ctl_reg <= '0;
            st2_ctl_reg <= '0;
            st3_ctl_reg <= '0;
        end
        else if (advance)
        begin
            st1_ctl_reg <= st1_ctl_next;
            st2_ctl_reg <= st1_ctl_reg;
            st3_ctl_reg <= st2_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st1_x_reg     <= st1_x_next;
            st1_y_reg     <= st1_y_next;
            st1_load_reg  <= load_address;
            st1_pixel_reg <= pixel_value;
            st2_cx0_reg   <= st2_cx0_next;
            st2_cx1_reg   <= st2_cx1_next;
            st2_cy0_reg   <= st2_cy0_next;
            st2_cy1_reg   <= st2_cy1_next;
            st2_load_reg  <= st1_load_reg;
            st2_pixel_reg <= st1_pixel_reg;
            st3_addr_reg  <= st3_addr_next;
            st3_load_reg  <= st2_load_reg;
            st3_pixel_reg <= st2_pixel_reg;
        end
    end

    assign ctl     = st3_ctl_reg;
    assign rd_addr = st3_addr_reg;
    assign wr_addr = st3_load_reg;
    assign wr_data = st3_pixel_reg;

    // the right and lower neighbours sit on or one past the clamped origin
    a_cx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (st2_ctl_reg.valid && st2_ctl_reg.sample) |->
        ((XB + 1)'(st2_cx1_reg) == (XB + 1)'(st2_cx0_reg)
         || (XB + 1)'(st2_cx1_reg) == (XB + 1)'(st2_cx0_reg) + 1'b1))
        else $error("x neighbour not adjacent after clamp");

    a_cy_step: assert property (@(posedge clk) disable iff (!rst_n)
        (st2_ctl_reg.valid && st2_ctl_reg.sample) |->
        ((YB + 1)'(st2_cy1_reg) == (YB + 1)'(st2_cy0_reg)
         || (YB + 1)'(st2_cy1_reg) == (YB + 1)'(st2_cy0_reg) + 1'b1))
        else $error("y neighbour not adjacent after clamp");

endmodule

`default_nettype wire

[design/ims_blend.sv]
// ----------------------------------------------------------------------------
// ims_blend: bilinear blend back end
// Takes the four tap words from the stores, blends along x, then along y,
// truncates and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ims_blend (
    input  wire logic                                                  clk,
    input  wire logic                                                  rst_n,
    input  wire logic                                                  advance,
    input  wire ims_pkg::ctl_t                                         ctl,
    input  wire logic [ims_pkg::TAP_COUNT-1:0][ims_pkg::PIXEL_BITS-1:0] pix,
    output logic                                                       out_valid,
    output logic [ims_pkg::RESULT_BITS-1:0]                            out_data
);

    localparam int PB = ims_pkg::PIXEL_BITS;
    localparam int FB = ims_pkg::FRAC_BITS;
    localparam int LB = ims_pkg::LERP_BITS;
    localparam int PW = PB + FB + 2;
    localparam int AW = LB + FB + 2;

    ims_pkg::ctl_t             st4_ctl_reg;
    ims_pkg::ctl_t             st5_ctl_reg;
    logic [LB-1:0]             st5_top_reg;
    logic [LB-1:0]             st5_bot_reg;
    logic                      out_valid_reg;
    logic [ims_pkg::RESULT_BITS-1:0] out_data_reg;

    logic signed [PB:0]        d_top;
    logic signed [PB:0]        d_bot;
    logic signed [PW-1:0]      s_top;
    logic signed [PW-1:0]      s_bot;
    logic [LB-1:0]             st5_top_next;
    logic [LB-1:0]             st5_bot_next;
    logic signed [LB:0]        d_y;
    logic signed [AW-1:0]      acc;
    logic [ims_pkg::RESULT_BITS-1:0] out_data_next;

    // stage 4: p0 * (1 - f) + p1 * f written as p0 * one + (p1 - p0) * f
    always_comb
    begin
        d_top = $signed({1'b0, pix[ims_pkg::TAP_10]}) - $signed({1'b0, pix[ims_pkg::TAP_00]});
        d_bot = $signed({1'b0, pix[ims_pkg::TAP_11]}) - $signed({1'b0, pix[ims_pkg::TAP_01]});
        s_top = $signed({2'b00, pix[ims_pkg::TAP_00], {FB{1'b0}}})
                + PW'(d_top) * PW'($signed({1'b0, st4_ctl_reg.fx}));
        s_bot = $signed({2'b00, pix[ims_pkg::TAP_01], {FB{1'b0}}})
                + PW'(d_bot) * PW'($signed({1'b0, st4_ctl_reg.fx}));
        st5_top_next = s_top[LB-1:0];
        st5_bot_next = s_bot[LB-1:0];
    end

    // stage 5: blend along y and drop both fractions
    always_comb
    begin
        d_y = $signed({1'b0, st5_bot_reg}) - $signed({1'b0, st5_top_reg});
        acc = $signed({2'b00, st5_top_reg, {FB{1'b0}}})
              + AW'(d_y) * AW'($signed({1'b0, st5_ctl_reg.fy}));
        out_data_next = ims_pkg::RESULT_BITS'(acc[PB+2*FB-1:2*FB]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st4_ctl_reg   <= '0;
            st5_ctl_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            st4_ctl_reg   <= ctl;
            st5_ctl_reg   <= st4_ctl_reg;
            // loads leave the pipe here without a word
            out_valid_reg <= st5_ctl_reg.valid && st5_ctl_reg.sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st5_top_reg  <= st5_top_next;
            st5_bot_reg  <= st5_bot_next;
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && st5_ctl_reg.valid && !st5_ctl_reg.sample) |=> !out_valid_reg)
        else $error("load produced a result word");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(st5_ctl_reg) && $stable(st4_ctl_reg)))
        else $error("blend stages moved during a stall");

endmodule

`default_nettype wire

[design/image_sampler_bilinear_clamp_core.sv]
// ----------------------------------------------------------------------------
// image_sampler_bilinear_clamp_core: clamped bilinear / nearest image sampler
// Loads pixels into a row-major store and samples it at Q12.8 coordinates.
// ----------------------------------------------------------------------------
// Input words arrive on s_tvalid/s_tready. s_tuser selects the kind: a load
// writes pixel_value at load_address and returns nothing; a sample returns
// one sample_value word on m_tvalid/m_tready. Words leave in input order.
// The pipe takes one word per cycle while the output is not stalled. A sample
// word reaches m_tvalid through the coordinate, clamp, address, store read and
// x blend registers, then the y blend into the output register.
// The store is held four times, one copy per neighbour tap, so all four
// taps read in the same cycle; every load writes all four copies.
// A stalled receiver holds the output register; the whole pipe then holds
// and s_tready falls in the same cycle, so no word is lost or repeated.
// Reset clears all valid bits and sets the registers to bilinear mode,
// a zero window origin and a 256 by 256 image. The store is not cleared:
// a pixel must be loaded before it is sampled.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must do so
// only while no word is in flight, as the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module image_sampler_bilinear_clamp_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // load_address[15:0], pixel_value[31:16], coord_x[51:32], coord_y[71:52]
    input  wire logic [ims_pkg::S_DATA_BITS-1:0]       s_tdata,
    // mode[0]
    input  wire logic [ims_pkg::MODE_BITS-1:0]         s_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // sample_value[15:0]
    output logic [ims_pkg::M_DATA_BITS-1:0]            m_tdata,
    input  wire logic                                  cfg_we,
    input  wire logic [ims_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  wire logic [ims_pkg::CFG_BITS-1:0]          cfg_data
);

    localparam int LB = ims_pkg::LOAD_BITS;
    localparam int VB = ims_pkg::VALUE_BITS;
    localparam int CB = ims_pkg::COORD_BITS;

    logic                                   filter_mode_reg;
    logic signed [ims_pkg::WIN_BITS-1:0]    window_min_x_reg;
    logic signed [ims_pkg::WIN_BITS-1:0]    window_min_y_reg;
    logic [ims_pkg::DIM_BITS-1:0]           image_width_reg;
    logic [ims_pkg::DIM_BITS-1:0]           image_height_reg;

    ims_pkg::cfg_t                          cfg;
    ims_pkg::ctl_t                          fetch_ctl;
    logic                                   advance;
    logic                                   out_valid;
    logic [ims_pkg::RESULT_BITS-1:0]        out_data;
    logic [ims_pkg::TAP_COUNT-1:0][ims_pkg::ADDR_BITS-1:0]  rd_addr;
    logic [ims_pkg::TAP_COUNT-1:0][ims_pkg::PIXEL_BITS-1:0] pix;
    logic [LB-1:0]                          wr_addr;
    logic [VB-1:0]                          wr_data;
    logic                                   wr_en;
    logic                                   rd_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg  <= ims_pkg::FILTER_BILINEAR;
            window_min_x_reg <= '0;
            window_min_y_reg <= '0;
            image_width_reg  <= ims_pkg::DIM_BITS'(256);
            image_height_reg <= ims_pkg::DIM_BITS'(256);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ims_pkg::REG_FILTER_MODE:  filter_mode_reg  <= cfg_data[0];
                ims_pkg::REG_WINDOW_MIN_X: window_min_x_reg <= $signed(cfg_data);
                ims_pkg::REG_WINDOW_MIN_Y: window_min_y_reg <= $signed(cfg_data);
                ims_pkg::REG_IMAGE_WIDTH:
                    image_width_reg  <= cfg_data[ims_pkg::DIM_BITS-1:0];
                ims_pkg::REG_IMAGE_HEIGHT:
                    image_height_reg <= cfg_data[ims_pkg::DIM_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.filter_mode  = filter_mode_reg;
        cfg.window_min_x = window_min_x_reg;
        cfg.window_min_y = window_min_y_reg;
        cfg.image_width  = image_width_reg;
        cfg.image_height = image_height_reg;
    end

    // hold the whole pipe while the output word waits
    assign advance  = !out_valid || m_tready;
    assign s_tready = advance;

    ims_addr u_addr (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .in_valid     (s_tvalid),
        .in_sample    (s_tuser[0] == ims_pkg::MODE_SAMPLE),
        .load_address (s_tdata[LB-1:0]),
        .pixel_value  (s_tdata[LB+VB-1:LB]),
        .coord_x      (s_tdata[LB+VB+CB-1:LB+VB]),
        .coord_y      (s_tdata[LB+VB+2*CB-1:LB+VB+CB]),
        .cfg          (cfg),
        .ctl          (fetch_ctl),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    // drop loads beyond the store
    assign wr_en = advance && fetch_ctl.valid && !fetch_ctl.sample
                   && (32'(wr_addr) < 32'(ims_pkg::STORE_DEPTH));
    assign rd_en = advance && fetch_ctl.valid && fetch_ctl.sample;

    for (genvar t = 0; t < ims_pkg::TAP_COUNT; t++)
    begin : g_tap
        ims_ram #(
            .WIDTH (ims_pkg::PIXEL_BITS),
            .DEPTH (ims_pkg::STORE_DEPTH)
        ) u_store (
            .clk     (clk),
            .wr_en   (wr_en),
            .wr_addr (ims_pkg::ADDR_BITS'(wr_addr)),
            .wr_data (ims_pkg::PIXEL_BITS'(wr_data)),
            .rd_en   (rd_en),
            .rd_addr (rd_addr[t]),
            .rd_data (pix[t])
        );
    end

    ims_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .ctl       (fetch_ctl),
        .pix       (pix),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = ims_pkg::M_DATA_BITS'(out_data);

endmodule

`default_nettype wire
